/* rtl/core/ilid_pkg.sv */
// ilid_pkg: shared widths, operation and status codes, and the cell control
// struct for the indexed list core. No dependencies.
package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int OP_W     = 3;
  localparam int POS_W    = 16;
  localparam int IDX_W    = POS_W - 1;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_INDEX  = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BADINDEX = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Broadcast to every cell for one item
  typedef struct packed {
    logic              shift_up;    // insert at pos
    logic              shift_down;  // delete at pos
    logic              get;         // drive the addressed cell into the tree
    logic [IDX_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } cell_ctrl_t;

endpackage

/* rtl/core/indexed_list_insert_delete_core.sv */
// indexed_list_insert_delete_core: bounded ordered list of signed values kept
// in a chain of shifting cells. Depends on ilid_pkg, ilid_cell, ilid_tree.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   item     | item_valid / item_ready   | operation, position, item_value
//   result   | result_valid/result_ready | read_value, found, status
//
// One item at a time: the wait from accept to the next accept is set by
// the depth of the registered OR tree that reads the addressed cell.
// Inserts and deletes shift the affected cells together in the execute
// state. The result sits in an output register; a stalled result holds the
// core in its last step only. rst is synchronous; the list is empty after it.
module indexed_list_insert_delete_core #(
  parameter int CAPACITY = ilid_pkg::CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [ilid_pkg::OP_W-1:0]           operation,
  input  logic signed [ilid_pkg::POS_W-1:0]   position,
  input  logic signed [ilid_pkg::VAL_W-1:0]   item_value,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [ilid_pkg::VAL_W-1:0]   read_value,
  output logic                                found,
  output logic [ilid_pkg::STAT_W-1:0]         status
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int LVL   = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(LVL + 1);
  localparam int VW    = ilid_pkg::VAL_W;
  localparam int IW    = ilid_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_TREE = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 count;
  logic [CNT_W-1:0]              wait_cnt;
  logic [ilid_pkg::OP_W-1:0]     req_op;
  logic [ilid_pkg::POS_W-1:0]    req_pos;
  logic [VW-1:0]                 req_value;
  ilid_pkg::status_t             res_status;
  logic                          res_found;

  // Decode of the held item
  ilid_pkg::cell_ctrl_t          ctrl;
  ilid_pkg::status_t             st_next;
  logic                          get_ok;
  logic                          ins_ok;
  logic                          del_ok;
  logic                          neg;
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 cnt_ext;
  logic                          full;
  logic [IW-1:0]                 ins_pos;

  logic [VW-1:0]                 vals   [CAPACITY];
  logic [CAPACITY-1:0][VW-1:0]   leaves;
  logic [VW-1:0]                 root;

  assign neg     = req_pos[ilid_pkg::POS_W-1];
  assign idx     = req_pos[IW-1:0];
  assign cnt_ext = IW'(count);
  assign full    = (count == CW'(CAPACITY));

  // Operation decode: status, insert slot and which shift to do
  always_comb begin
    st_next = ilid_pkg::ST_BADINDEX;
    get_ok  = 1'b0;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    ins_pos = '0;
    unique case (ilid_pkg::op_t'(req_op))
      ilid_pkg::OP_GET: begin
        if (!neg && (idx < cnt_ext)) begin
          get_ok  = 1'b1;
          st_next = ilid_pkg::ST_DONE;
        end
      end
      ilid_pkg::OP_HEAD: begin
        st_next = full ? ilid_pkg::ST_FULL : ilid_pkg::ST_DONE;
        ins_ok  = !full;
      end
      ilid_pkg::OP_TAIL: begin
        ins_pos = cnt_ext;
        st_next = full ? ilid_pkg::ST_FULL : ilid_pkg::ST_DONE;
        ins_ok  = !full;
      end
      ilid_pkg::OP_INDEX: begin
        if (neg) begin
          st_next = full ? ilid_pkg::ST_FULL : ilid_pkg::ST_DONE;
          ins_ok  = !full;
        end else if (idx <= cnt_ext) begin
          ins_pos = idx;
          st_next = full ? ilid_pkg::ST_FULL : ilid_pkg::ST_DONE;
          ins_ok  = !full;
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (!neg && (idx < cnt_ext)) begin
          del_ok  = 1'b1;
          st_next = ilid_pkg::ST_DONE;
        end
      end
      default: st_next = ilid_pkg::ST_BADINDEX;
    endcase
  end

  // Cell command: shifts only in the execute cycle, read tap held for the tree
  always_comb begin
    ctrl.shift_up   = (state == S_EXEC) && ins_ok;
    ctrl.shift_down = (state == S_EXEC) && del_ok;
    ctrl.get        = get_ok;
    ctrl.pos        = del_ok ? idx : (get_ok ? idx : ins_pos);
    ctrl.value      = req_value;
  end

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] below_v;
    logic [VW-1:0] above_v;
    if (i == 0) begin : g_first
      assign below_v = '0;
    end else begin : g_mid_lo
      assign below_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above_v = '0;
    end else begin : g_mid_hi
      assign above_v = vals[i+1];
    end
    ilid_cell #(.INDEX(i)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .below (below_v),
      .above (above_v),
      .data  (vals[i]),
      .leaf  (leaves[i])
    );
  end

  ilid_tree #(.LEAVES(CAPACITY), .W(VW)) u_tree (
    .clk  (clk),
    .leaf (leaves),
    .root (root)
  );

  assign item_ready = (state == S_IDLE);

  // Sequencer and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      wait_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (ins_ok) count <= count + CW'(1);
          else if (del_ok) count <= count - CW'(1);
          wait_cnt <= CNT_W'(LVL);
          state    <= S_TREE;
        end
        S_TREE: begin
          if (wait_cnt == '0) state <= S_DONE;
          else wait_cnt <= wait_cnt - CNT_W'(1);
        end
        S_DONE: begin
          if (!result_valid || result_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item and decoded result capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      req_op    <= operation;
      req_pos   <= position;
      req_value <= item_value;
    end
    if (state == S_EXEC) begin
      res_status <= st_next;
      res_found  <= get_ok;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_DONE) && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!result_valid || result_ready)) begin
      read_value <= res_found ? root : '1;
      found      <= res_found;
      status     <= res_status;
    end
  end

endmodule

/* rtl/core/ilid_cell.sv */
// ilid_cell: one storage cell of the list chain; shifts with its neighbors.
// Depends on ilid_pkg.
module ilid_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  ilid_pkg::cell_ctrl_t              ctrl,
  input  logic [ilid_pkg::VAL_W-1:0]        below,
  input  logic [ilid_pkg::VAL_W-1:0]        above,
  output logic [ilid_pkg::VAL_W-1:0]        data,
  output logic [ilid_pkg::VAL_W-1:0]        leaf
);

  localparam logic [ilid_pkg::IDX_W-1:0] MY_IDX = ilid_pkg::IDX_W'(INDEX);

  // Insert moves cells above the slot up; delete pulls cells above down
  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      if (MY_IDX > ctrl.pos) data <= below;
      else if (MY_IDX == ctrl.pos) data <= ctrl.value;
    end else if (ctrl.shift_down && (MY_IDX >= ctrl.pos)) begin
      data <= above;
    end
  end

  // Read tap: only the addressed cell shows its value
  assign leaf = (ctrl.get && (MY_IDX == ctrl.pos)) ? data : '0;

endmodule

/* rtl/core/ilid_tree.sv */
// ilid_tree: registered OR-reduction tree that gathers the read taps of
// all cells, with the leaves and every OR level registered. Depends on nothing.
module ilid_tree #(
  parameter int LEAVES = 64,
  parameter int W      = 32
) (
  input  logic                        clk,
  input  logic [LEAVES-1:0][W-1:0]    leaf,
  output logic [W-1:0]                root
);

  localparam int LVL = $clog2(LEAVES);
  localparam int P   = 1 << LVL;

  logic [P-1:0][W-1:0] lf_pad;
  logic [W-1:0]        nd [2*P-1];

  assign lf_pad = (P*W)'(leaf);

  // Leaves registered at the bottom, each OR level above registered too
  always_ff @(posedge clk) begin
    for (int k = 0; k < P - 1; k++) begin
      nd[k] <= nd[2*k+1] | nd[2*k+2];
    end
    for (int k = 0; k < P; k++) begin
      nd[P-1+k] <= lf_pad[k];
    end
  end

  assign root = nd[0];

endmodule

/* rtl/core/ilid_checker.sv */
// ilid_checker: port-level checks on the indexed list core, bound to the top.
// Depends on ilid_pkg and indexed_list_insert_delete_core.
module ilid_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic signed [ilid_pkg::VAL_W-1:0]  read_value,
  input logic                               found,
  input logic [ilid_pkg::STAT_W-1:0]        status
);

  // A hit always reports done
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && found) |-> (status == ilid_pkg::ST_DONE))
    else $error("found item without done status");

  // Anything but a hit reads as all ones
  a_miss_ones: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (read_value == '1))
    else $error("miss item with read value other than -1");

  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second item accepted while busy");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(read_value) && $stable(status) && $stable(found)))
    else $error("stalled result changed");

endmodule

bind indexed_list_insert_delete_core ilid_checker u_ilid_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for indexed_list_insert_delete_core (needs ilid_pkg
// and the core). A queue shadows the list to predict each result; a directed
// table runs first, then fill/drain/churn traffic with random idling.
module tb;

  localparam int N_RANDOM    = 750;
  localparam int CALM_TAIL   = 100;   // last items run with no idling
  localparam int LONG_HOLD   = 80;    // one long receiver stall
  localparam int HOLD_AT     = 200;
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
  localparam int SETTLE      = 20;

  localparam logic [ilid_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [ilid_pkg::OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [ilid_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ilid_pkg::VAL_W-1:0] value;
    logic                       hit;
    ilid_pkg::status_t          code;
  } list_result_t;

  localparam list_result_t MISS = '{value: '1, hit: 1'b0, code: ilid_pkg::ST_BADINDEX};

  typedef struct {
    logic [ilid_pkg::OP_W-1:0]  op;
    logic [ilid_pkg::POS_W-1:0] pos;
    logic [ilid_pkg::VAL_W-1:0] val;
    bit                         miss;  // expectation typed in: not found / bad index
  } stim_row_t;

  typedef enum {FILL_UP, DRAIN_OUT, CHURN} traffic_mode_t;

  logic                              clk          = 1'b0;
  logic                              rst          = 1'b1;
  logic                              item_valid   = 1'b0;
  logic                              item_ready;
  logic [ilid_pkg::OP_W-1:0]         operation    = '0;
  logic signed [ilid_pkg::POS_W-1:0] position     = '0;
  logic signed [ilid_pkg::VAL_W-1:0] item_value   = '0;
  logic                              result_valid;
  logic                              result_ready = 1'b0;
  logic signed [ilid_pkg::VAL_W-1:0] read_value;
  logic                              found;
  logic [ilid_pkg::STAT_W-1:0]       status;

  logic [ilid_pkg::VAL_W-1:0] shadow_list[$];
  list_result_t               pending_results[$];
  stim_row_t                  directed_rows[$];
  int                         mismatches       = 0;
  int                         results_seen     = 0;
  int                         total_items      = 0;
  bit                         long_hold_active = 1'b0;
  bit                         long_hold_done   = 1'b0;

  indexed_list_insert_delete_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("%0t ns: mismatch on result %0d: %s", $time, results_seen, msg);
  endtask

  // Shadow list insert; full check only, callers handle the index range
  function automatic ilid_pkg::status_t shadow_insert(int at,
      logic [ilid_pkg::VAL_W-1:0] v);
    if (shadow_list.size() >= ilid_pkg::CAPACITY) return ilid_pkg::ST_FULL;
    shadow_list.insert(at, v);
    return ilid_pkg::ST_DONE;
  endfunction

  // Apply one item to the shadow list and return the result it should give
  function automatic list_result_t apply_list_op(logic [ilid_pkg::OP_W-1:0] op,
      logic signed [ilid_pkg::POS_W-1:0] pos, logic [ilid_pkg::VAL_W-1:0] v);
    list_result_t r;
    int           cnt;
    int           p;
    r = MISS;
    cnt = shadow_list.size();
    p = int'(pos);
    case (op)
      ilid_pkg::OP_GET: begin
        if (p >= 0 && p < cnt) begin
          r.value = shadow_list[p];
          r.hit = 1'b1;
          r.code = ilid_pkg::ST_DONE;
        end
      end
      ilid_pkg::OP_HEAD: r.code = shadow_insert(0, v);
      ilid_pkg::OP_TAIL: r.code = shadow_insert(cnt, v);
      ilid_pkg::OP_INDEX: begin
        if (p < 0) r.code = shadow_insert(0, v);
        else if (p <= cnt) r.code = shadow_insert(p, v);
      end
      ilid_pkg::OP_DELETE: begin
        if (p >= 0 && p < cnt) begin
          shadow_list.delete(p);
          r.code = ilid_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [ilid_pkg::OP_W-1:0] op,
      logic [ilid_pkg::POS_W-1:0] pos, logic [ilid_pkg::VAL_W-1:0] v, bit miss);
    stim_row_t row;
    row.op = op;
    row.pos = pos;
    row.val = v;
    row.miss = miss;
    directed_rows.push_back(row);
  endfunction

  // Hold one item on the input until accepted, then queue its expectation
  task automatic offer_item(logic [ilid_pkg::OP_W-1:0] op,
      logic [ilid_pkg::POS_W-1:0] pos, logic [ilid_pkg::VAL_W-1:0] v, bit miss);
    list_result_t predicted;
    item_valid <= 1'b1;
    operation  <= op;
    position   <= pos;
    item_value <= v;
    do @(posedge clk); while (!item_ready);
    predicted = apply_list_op(op, pos, v);
    pending_results.push_back(miss ? MISS : predicted);
  endtask

  task automatic maybe_pause(int idle_pct);
    if (idle_pct > 0 && !long_hold_active && $urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [ilid_pkg::OP_W-1:0] pick_op(traffic_mode_t mode);
    int r;
    int ins_lim;
    int get_lim;
    int del_lim;
    r = $urandom_range(0, 99);
    case (mode)
      FILL_UP: begin
        ins_lim = 75; get_lim = 88; del_lim = 95;
      end
      DRAIN_OUT: begin
        ins_lim = 10; get_lim = 30; del_lim = 95;
      end
      default: begin
        ins_lim = 35; get_lim = 62; del_lim = 92;
      end
    endcase
    if (r < ins_lim) begin
      case ($urandom_range(0, 2))
        0: return ilid_pkg::OP_HEAD;
        1: return ilid_pkg::OP_TAIL;
        default: return ilid_pkg::OP_INDEX;
      endcase
    end
    if (r < get_lim) return ilid_pkg::OP_GET;
    if (r < del_lim) return ilid_pkg::OP_DELETE;
    return ilid_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // Indexed ops mostly land in or just past the list; some negative or huge
  function automatic logic [ilid_pkg::POS_W-1:0] pick_position(
      logic [ilid_pkg::OP_W-1:0] op);
    int cnt;
    int r;
    cnt = shadow_list.size();
    r = $urandom_range(0, 99);
    if (!(op inside {ilid_pkg::OP_GET, ilid_pkg::OP_INDEX, ilid_pkg::OP_DELETE}))
      return ilid_pkg::POS_W'($urandom);
    if (r < 70) return ilid_pkg::POS_W'($urandom_range(0, cnt));
    if (r < 80) return ilid_pkg::POS_W'(cnt + 1);
    if (r < 90) return ilid_pkg::POS_W'($urandom) | {1'b1, {ilid_pkg::IDX_W{1'b0}}};
    return ilid_pkg::POS_W'($urandom);
  endfunction

  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result value=%h found=%b status=%0d",
                              read_value, found, status));
      return;
    end
    want = pending_results.pop_front();
    if (read_value !== want.value)
      flag_mismatch($sformatf("read_value %h, expected %h", read_value, want.value));
    if (found !== want.hit)
      flag_mismatch($sformatf("found %b, expected %b", found, want.hit));
    if (status !== want.code)
      flag_mismatch($sformatf("status %0d, expected %0d", status, want.code));
  endtask

  // Stimulus: reset, directed table, then mode-driven random traffic
  initial begin
    traffic_mode_t             mode;
    int                        spare;
    int                        churn_left;
    int                        tx_idle_pct;
    logic [ilid_pkg::OP_W-1:0] op;

    // empty list, bad indexes, unused codes
    add_row(ilid_pkg::OP_GET,    16'h0000, 32'h0000_0000, 1'b1);
    add_row(ilid_pkg::OP_DELETE, 16'h0000, 32'hFFFF_FFFF, 1'b1);
    add_row(ilid_pkg::OP_GET,    16'hFFFF, 32'h0000_0000, 1'b1);
    add_row(OP_UNUSED_LO,        16'h0000, 32'h1234_5678, 1'b1);
    add_row(OP_UNUSED_HI,        16'h0000, 32'hFFFF_FFFF, 1'b1);
    // value extremes, negative index goes to head, index == count appends
    add_row(ilid_pkg::OP_HEAD,   16'h0000, 32'h7FFF_FFFF, 1'b0);
    add_row(ilid_pkg::OP_TAIL,   16'h0000, 32'h8000_0000, 1'b0);
    add_row(ilid_pkg::OP_INDEX,  16'hFFFF, 32'h0000_0000, 1'b0);
    add_row(ilid_pkg::OP_INDEX,  16'h0003, 32'hFFFF_FFFF, 1'b0);
    // insert past the end is ignored (count is 4 here)
    add_row(ilid_pkg::OP_INDEX,  16'h0005, 32'h0000_0001, 1'b1);
    add_row(ilid_pkg::OP_INDEX,  16'h7FFF, 32'h0000_0001, 1'b1);
    add_row(ilid_pkg::OP_GET,    16'h8000, 32'h0000_0000, 1'b1);
    add_row(ilid_pkg::OP_GET,    16'h7FFF, 32'h0000_0000, 1'b1);
    add_row(ilid_pkg::OP_GET,    16'h0000, 32'h0000_0000, 1'b0);
    add_row(ilid_pkg::OP_GET,    16'h0003, 32'h0000_0000, 1'b0);
    add_row(ilid_pkg::OP_GET,    16'h0004, 32'h0000_0000, 1'b1);
    add_row(ilid_pkg::OP_DELETE, 16'hFFFF, 32'h0000_0000, 1'b1);
    add_row(ilid_pkg::OP_DELETE, 16'h0004, 32'h0000_0000, 1'b1);
    add_row(ilid_pkg::OP_DELETE, 16'h0001, 32'h0000_0000, 1'b0);
    add_row(ilid_pkg::OP_GET,    16'h0001, 32'h0000_0000, 1'b0);
    add_row(OP_UNUSED_MID,       16'h8000, 32'hFFFF_FFFF, 1'b1);
    add_row(ilid_pkg::OP_DELETE, 16'h0000, 32'h0000_0000, 1'b0);
    // position is don't-care for head and tail
    add_row(ilid_pkg::OP_HEAD,   16'h8000, 32'h5A5A_5A5A, 1'b0);
    add_row(ilid_pkg::OP_TAIL,   16'h7FFF, 32'hA5A5_A5A5, 1'b0);
    total_items = directed_rows.size() + N_RANDOM;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].op, directed_rows[i].pos,
                 directed_rows[i].val, directed_rows[i].miss);
      maybe_pause(15);
    end

    mode = FILL_UP;
    spare = 0;
    churn_left = 0;
    tx_idle_pct = 15;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
      op = pick_op(mode);
      offer_item(op, pick_position(op), $urandom, 1'b0);

      // fill to capacity and beat on it, drain to empty, churn, repeat
      case (mode)
        FILL_UP: begin
          if (shadow_list.size() == ilid_pkg::CAPACITY) spare++;
          if (spare >= 8) begin
            mode = DRAIN_OUT;
            spare = 0;
          end
        end
        DRAIN_OUT: begin
          if (shadow_list.size() == 0) spare++;
          if (spare >= 6) begin
            mode = CHURN;
            spare = 0;
            churn_left = $urandom_range(20, 60);
          end
        end
        default: begin
          churn_left--;
          if (churn_left <= 0) mode = FILL_UP;
        end
      endcase

      if (N_RANDOM - n > CALM_TAIL) maybe_pause(tx_idle_pct);
    end
    item_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("** indexed_list_insert_delete_core: PASSED **");
    else
      $display("** indexed_list_insert_delete_core: FAILED **");
    $finish;
  end

  // Result side: random stall bursts, one long hold to back up the input
  initial begin
    int hold_left;
    int rx_idle_pct;
    hold_left = 0;
    rx_idle_pct = 12;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        check_result();
        results_seen++;
        if (results_seen % 64 == 0) rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (results_seen == HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        long_hold_active = 1'b1;
        hold_left = LONG_HOLD - 1;
        result_ready <= 1'b0;
      end else if (results_seen < total_items - CALM_TAIL &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        hold_left = $urandom_range(1, 11) - 1;
        result_ready <= 1'b0;
      end else begin
        long_hold_active = 1'b0;
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake means the core is hung
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("** indexed_list_insert_delete_core: FAILED **");
    $finish;
  end

endmodule

/* indexed_list_insert_delete_core.f */
rtl/core/ilid_pkg.sv
rtl/core/ilid_cell.sv
rtl/core/ilid_tree.sv
rtl/core/indexed_list_insert_delete_core.sv
rtl/core/ilid_checker.sv
test/tb.sv
